// File: design/viue_pkg.sv
// shared types and constants for the variable-length integer encoder
package viue_pkg;

  localparam int VALUE_W    = 64;
  localparam int BYTE_W     = 8;
  localparam int GROUP_W    = 7;
  localparam int LAST_MAG_W = 6;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctrl_t;

endpackage

// File: design/viue_in_if.sv
// input channel: one integer and its signedness flag per request
interface viue_in_if;
  logic                         valid;
  logic                         ready;
  logic [viue_pkg::VALUE_W-1:0] value;
  logic                         is_signed;

  modport source(output valid, value, is_signed, input ready);
  modport sink(input valid, value, is_signed, output ready);
endinterface

// File: design/viue_out_if.sv
// output channel: one encoded byte per transfer with a last marker
interface viue_out_if;
  logic                  valid;
  logic                  ready;
  logic [viue_pkg::BYTE_W-1:0] code_byte;
  logic                  last;

  modport source(output valid, code_byte, last, input ready);
  modport sink(input valid, code_byte, last, output ready);
endinterface

// File: design/varint_uint_int_encoder.sv
// Variable-length integer encoder, most significant group first. Each request
// carries a value (low VALUE_BITS bits used) and an is_signed flag; the block
// answers with one to ceil(VALUE_BITS/7) bytes, last set on the final one.
// Unsigned values use 7-bit groups with bit 7 set on all but the last byte;
// signed values are sign and magnitude with the sign in bit 0 of the last
// byte, and the most negative value is sent as the most negative plus one.
// One 7-bit group shift register does all the work. After a request is
// taken, the block drops each leading zero group, then finds the first
// group, then sends one byte per remaining group, waiting while the output
// stalls; it takes no new request until the final byte has been registered.
// The final byte sits in an output register, so the next request is taken
// while that byte still waits.
module varint_uint_int_encoder #(
  parameter int VALUE_BITS = 64
) (
  input logic      clk,
  input logic      rst,
  viue_in_if.sink  item,
  viue_out_if.source code
);
  import viue_pkg::*;

  localparam int NGRP      = (VALUE_BITS + GROUP_W - 1) / GROUP_W;
  localparam int WORD_BITS = NGRP * GROUP_W;
  localparam int CNT_W     = $clog2(NGRP + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     rem_next;
  logic                 sgn;
  logic                 neg;
  logic                 out_valid;
  byte_t                out_byte;
  logic                 out_last;

  logic [WORD_BITS-1:0] conv_word;
  logic                 conv_neg;
  logic [GROUP_W-1:0]   top_grp;
  shift_ctrl_t          ctrl;
  byte_t                byte_next;
  logic                 accept;
  logic                 out_free;
  logic                 emit;
  logic                 last_grp;
  logic                 skip;

  viue_sm_conv #(
    .VALUE_BITS(VALUE_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_conv (
    .value    (item.value),
    .is_signed(item.is_signed),
    .word     (conv_word),
    .neg      (conv_neg)
  );

  viue_grp_shift #(
    .WORD_BITS(WORD_BITS)
  ) u_shift (
    .clk      (clk),
    .ctrl     (ctrl),
    .load_word(conv_word),
    .top_grp  (top_grp)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || code.ready;
  assign emit       = (state == S_EMIT) && out_free;
  assign last_grp   = (rem == CNT_W'(1));
  // drop leading zero groups, always keeping the final one
  assign skip       = (state == S_SCAN) && (top_grp == '0) && !last_grp;

  assign ctrl.load  = accept;
  assign ctrl.shift = skip || emit;

  always_comb begin
    state_next = state;
    rem_next   = rem;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
          rem_next   = CNT_W'(NGRP);
        end
      end
      S_SCAN: begin
        if (skip) begin
          rem_next = rem - CNT_W'(1);
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          rem_next = rem - CNT_W'(1);
          if (last_grp) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (!last_grp) begin
      byte_next = {1'b1, top_grp};
    end else if (sgn) begin
      byte_next = {1'b0, top_grp[LAST_MAG_W-1:0], neg};
    end else begin
      byte_next = {1'b0, top_grp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rem   <= rem_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (code.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sgn <= item.is_signed;
      neg <= conv_neg;
    end
    if (emit) begin
      out_byte <= byte_next;
      out_last <= last_grp;
    end
  end

  assign code.valid     = out_valid;
  assign code.code_byte = out_byte;
  assign code.last      = out_last;

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (rem != '0))
    else $error("group count empty while busy");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && (rem == CNT_W'(NGRP)))
    else $error("request not loaded with full group count");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && last_grp) |=> (state == S_IDLE) && out_valid && out_last)
    else $error("final byte did not end the encoding");

  a_mid_marked: assert property (@(posedge clk) disable iff (rst)
    (emit && !last_grp) |=> out_byte[BYTE_W-1] && !out_last)
    else $error("continuation byte lacks its marker");
endmodule

// File: design/viue_sm_conv.sv
// converts the input into a group-aligned word, sign-magnitude when signed
module viue_sm_conv #(
  parameter int VALUE_BITS = 64,
  parameter int WORD_BITS  = 70
) (
  input  logic [viue_pkg::VALUE_W-1:0] value,
  input  logic                         is_signed,
  output logic [WORD_BITS-1:0]         word,
  output logic                         neg
);
  import viue_pkg::*;

  localparam logic [VALUE_BITS-1:0] TOP = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] negv;
  logic [VALUE_BITS-2:0] mag;

  assign v    = value[VALUE_BITS-1:0];
  assign neg  = is_signed && v[VALUE_BITS-1];
  assign negv = ~v + VALUE_BITS'(1);

  // the most negative value saturates to the largest magnitude
  always_comb begin
    if (!neg) begin
      mag = v[VALUE_BITS-2:0];
    end else if (v == TOP) begin
      mag = '1;
    end else begin
      mag = negv[VALUE_BITS-2:0];
    end
  end

  // signed: lowest group holds six magnitude bits, a spare bit above them
  always_comb begin
    word = '0;
    if (is_signed) begin
      word[VALUE_BITS-1:GROUP_W] = mag[VALUE_BITS-2:LAST_MAG_W];
      word[LAST_MAG_W-1:0]       = mag[LAST_MAG_W-1:0];
    end else begin
      word[VALUE_BITS-1:0] = v;
    end
  end
endmodule

// File: design/viue_grp_shift.sv
// group shift register: holds the word and moves it up one 7-bit group a step
module viue_grp_shift #(
  parameter int WORD_BITS = 70
) (
  input  logic                          clk,
  input  viue_pkg::shift_ctrl_t         ctrl,
  input  logic [WORD_BITS-1:0]          load_word,
  output logic [viue_pkg::GROUP_W-1:0]  top_grp
);
  import viue_pkg::*;

  logic [WORD_BITS-1:0] word;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= load_word;
    end else if (ctrl.shift) begin
      word <= {word[WORD_BITS-GROUP_W-1:0], GROUP_W'(0)};
    end
  end

  assign top_grp = word[WORD_BITS-1 -: GROUP_W];
endmodule

// File: tb/sv/varint_uint_int_encoder_tb.sv
// self-checking testbench for the variable-length integer encoder
module varint_uint_int_encoder_tb;
  import viue_pkg::*;

  localparam int MAX_BYTES = 10;
  localparam int DIR_ROWS = 22;
  localparam int RAND_PER_PHASE = 65;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [VALUE_W-1:0] TOP = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] ONES = '1;

  typedef struct packed {
    byte_t code_byte;
    logic last;
  } code_beat_t;

  // nb == 0 means the expected bytes come from the predictor
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic sgn;
    logic [1:0] nb;
    byte_t b0;
    byte_t b1;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{64'd0, 1'b0, 2'd1, 8'h00, 8'h00},
    '{64'd0, 1'b1, 2'd1, 8'h00, 8'h00},
    '{64'd1, 1'b0, 2'd1, 8'h01, 8'h00},
    '{64'd127, 1'b0, 2'd1, 8'h7f, 8'h00},
    '{64'd128, 1'b0, 2'd2, 8'h81, 8'h00},
    '{64'd16383, 1'b0, 2'd2, 8'hff, 8'h7f},
    '{64'd16384, 1'b0, 2'd0, 8'h00, 8'h00},
    '{64'd1, 1'b1, 2'd1, 8'h02, 8'h00},
    '{64'hffff_ffff_ffff_ffff, 1'b1, 2'd1, 8'h03, 8'h00},
    '{64'd63, 1'b1, 2'd1, 8'h7e, 8'h00},
    '{64'hffff_ffff_ffff_ffc1, 1'b1, 2'd1, 8'h7f, 8'h00},
    '{64'd64, 1'b1, 2'd2, 8'h81, 8'h00},
    '{64'hffff_ffff_ffff_ffc0, 1'b1, 2'd2, 8'h81, 8'h01},
    '{64'd8191, 1'b1, 2'd2, 8'hff, 8'h7e},
    '{64'hffff_ffff_ffff_e000, 1'b1, 2'd0, 8'h00, 8'h00},
    '{64'hffff_ffff_ffff_ffff, 1'b0, 2'd0, 8'h00, 8'h00},
    '{64'h8000_0000_0000_0000, 1'b0, 2'd0, 8'h00, 8'h00},
    '{64'h7fff_ffff_ffff_ffff, 1'b0, 2'd0, 8'h00, 8'h00},
    '{64'h8000_0000_0000_0000, 1'b1, 2'd0, 8'h00, 8'h00},
    '{64'h8000_0000_0000_0001, 1'b1, 2'd0, 8'h00, 8'h00},
    '{64'h7fff_ffff_ffff_ffff, 1'b1, 2'd0, 8'h00, 8'h00},
    '{64'haaaa_aaaa_aaaa_aaaa, 1'b1, 2'd0, 8'h00, 8'h00}
  };

  logic clk;
  logic rst;
  int sender_idle_pct;
  int receiver_stall_pct;
  int err_count;
  int cycles = 0;
  code_beat_t pending_bytes [$];

  viue_in_if item_if ();
  viue_out_if code_if ();

  varint_uint_int_encoder #(
    .VALUE_BITS(VALUE_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item(item_if.sink),
    .code(code_if.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0h, want %0h (cycle %0d)", field, got, want, cycles);
    err_count++;
  endtask

  // expected bytes of one value, most significant group first
  task automatic predict_encoding(input logic [VALUE_W-1:0] raw, input logic sgn);
    logic [VALUE_W-1:0] mag;
    logic neg;
    byte_t grp [MAX_BYTES];
    int n;
    code_beat_t beat;
    n = 0;
    neg = 1'b0;
    mag = raw;
    if (!sgn) begin
      do begin
        grp[n] = {1'b0, mag[6:0]};
        mag = mag >> 7;
        n++;
      end while (mag != 0 && n < MAX_BYTES);
    end else begin
      neg = raw[VALUE_W-1];
      if (neg) begin
        mag = -raw;
        // most negative saturates to one above it
        if (mag == TOP) mag = TOP - 1;
      end
      grp[0] = {2'b00, mag[5:0]};
      mag = mag >> 6;
      n = 1;
      while (mag != 0 && n < MAX_BYTES) begin
        grp[n] = {1'b0, mag[6:0]};
        mag = mag >> 7;
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (k > 0) beat.code_byte = grp[k] | 8'h80;
      else if (sgn) beat.code_byte = {1'b0, grp[0][5:0], neg};
      else beat.code_byte = grp[0];
      beat.last = (k == 0);
      pending_bytes = {pending_bytes, beat};
    end
  endtask

  // one request; returns at the edge where it is taken
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic sgn,
                            input logic [1:0] nb, input byte_t b0, input byte_t b1);
    code_beat_t beat;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.value <= v;
    item_if.is_signed <= sgn;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    if (nb == 0) begin
      predict_encoding(v, sgn);
    end else begin
      beat.code_byte = b0;
      beat.last = (nb == 1);
      pending_bytes = {pending_bytes, beat};
      if (nb == 2) begin
        beat.code_byte = b1;
        beat.last = 1'b1;
        pending_bytes = {pending_bytes, beat};
      end
    end
  endtask

  task automatic drain_bytes();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(input logic sgn);
    logic [VALUE_W-1:0] v;
    int w;
    int kind;
    kind = $urandom_range(9);
    v = {$urandom, $urandom};
    if (kind <= 5) begin
      // mostly values of random bit width, giving encodings of random length
      w = $urandom_range(VALUE_W, 1);
      if (w < VALUE_W) v = v & ((64'd1 << w) - 1);
      if (sgn && $urandom_range(1)) v = -v;
    end else if (kind == 7) begin
      v = 64'd1 << $urandom_range(VALUE_W - 1);
      case ($urandom_range(3))
        1: v = v - 1;
        2: v = -v;
        3: v = -(v - 1);
        default: ;
      endcase
    end else if (kind == 8) begin
      case ($urandom_range(3))
        0: v = TOP;
        1: v = TOP - 1;
        2: v = ONES;
        default: v = TOP + 1;
      endcase
    end else if (kind == 9) begin
      case ($urandom_range(2))
        0: v = '0;
        1: v = 64'd1;
        default: v = ONES;
      endcase
    end
    return v;
  endfunction

  // output side: random stalls and byte check
  always @(posedge clk) begin
    code_beat_t beat;
    cycles <= cycles + 1;
    code_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    if (!rst && code_if.valid && code_if.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", code_if.code_byte, 0);
      end else begin
        beat = pending_bytes.pop_front();
        if (code_if.code_byte !== beat.code_byte)
          report_mismatch("code_byte", code_if.code_byte, beat.code_byte);
        if (code_if.last !== beat.last)
          report_mismatch("last", code_if.last, beat.last);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("varint_uint_int_encoder_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic sgn;
    err_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst <= 1'b1;
    item_if.valid <= 1'b0;
    item_if.value <= '0;
    item_if.is_signed <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_value(DIR_TABLE[i].value, DIR_TABLE[i].sgn, DIR_TABLE[i].nb,
                 DIR_TABLE[i].b0, DIR_TABLE[i].b1);
    drain_bytes();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 54; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 54; end
        default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
      endcase
      repeat (RAND_PER_PHASE) begin
        sgn = 1'($urandom_range(1));
        send_value(pick_value(sgn), sgn, 2'd0, 8'h00, 8'h00);
      end
      drain_bytes();
    end

    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("varint_uint_int_encoder_tb OK");
    end else begin
      $display("varint_uint_int_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
